// ===== rtl/core/tacavg_pkg.sv =====
package tacavg_pkg;

   // Block configuration
   localparam int CHANNELS        = 8;
   localparam int MAX_BURST_WORDS = 64;

   // Field and state widths
   localparam int WORD_W   = 32;
   localparam int HALF_W   = 16;
   localparam int TAG_LSB  = 12;
   localparam int TAG_W    = 3;
   localparam int VAL_W    = 12;
   localparam int SUM_W    = 19;
   localparam int CNT_W    = 8;
   localparam int AVG_W    = 12;
   localparam int WCNT_W   = 7;
   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // Divider sequencing: one quotient bit per cycle over the whole sum
   localparam int DIV_STEPS  = SUM_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

   // Burst queue between front and back
   localparam int JOBQ_DEPTH = 2;
   localparam int JOBQ_AW    = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;

   typedef struct packed {
      logic [WORD_W-1:0] fifo_word;
      logic              burst_end;
   } req_item_type;

   typedef struct packed {
      logic [TAG_W-1:0] channel;
      logic [AVG_W-1:0] average;
      logic             updated;
      logic             overflow;
      logic             run_last;
   } rsp_item_type;

   // One finished burst, handed from front to back
   typedef struct packed {
      logic [CHANNELS-1:0][SUM_W-1:0] sums;
      logic [CHANNELS-1:0][CNT_W-1:0] counts;
      logic                           dropped;
   } job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } jobq_status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_LOAD,
      BK_DIV,
      BK_EMIT
   } back_state_type;

endpackage

// ===== rtl/core/tacavg_front.sv =====
module tacavg_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  tacavg_pkg::req_item_type item,
   output logic                     job_push,
   output tacavg_pkg::job_type      job
);

   logic [tacavg_pkg::CHANNELS-1:0][tacavg_pkg::SUM_W-1:0] sums_ff, sums_in;
   logic [tacavg_pkg::CHANNELS-1:0][tacavg_pkg::CNT_W-1:0] counts_ff, counts_in;
   logic [tacavg_pkg::CHANNELS-1:0][tacavg_pkg::SUM_W-1:0] sums_add;
   logic [tacavg_pkg::CHANNELS-1:0][tacavg_pkg::CNT_W-1:0] counts_add;
   logic [tacavg_pkg::WCNT_W-1:0] words_ff, words_in;
   logic                          dropped_ff, dropped_in;
   logic                          room;
   logic [tacavg_pkg::HALF_W-1:0] half_lo, half_hi;
   logic [tacavg_pkg::TAG_W-1:0]  tag_lo, tag_hi;
   logic [tacavg_pkg::VAL_W-1:0]  val_lo, val_hi;

   // Split the word into its two tagged samples
   assign half_lo = item.fifo_word[tacavg_pkg::HALF_W-1:0];
   assign half_hi = item.fifo_word[tacavg_pkg::WORD_W-1:tacavg_pkg::HALF_W];
   assign tag_lo  = half_lo[tacavg_pkg::TAG_LSB +: tacavg_pkg::TAG_W];
   assign tag_hi  = half_hi[tacavg_pkg::TAG_LSB +: tacavg_pkg::TAG_W];
   assign val_lo  = half_lo[tacavg_pkg::VAL_W-1:0];
   assign val_hi  = half_hi[tacavg_pkg::VAL_W-1:0];

   assign room = (words_ff < tacavg_pkg::WCNT_W'(tacavg_pkg::MAX_BURST_WORDS));

   // Add both samples to their channels; tags past the last channel match nothing
   always_comb begin
      for (int c = 0; c < tacavg_pkg::CHANNELS; c++) begin
         sums_add[c] = sums_ff[c]
                     + ((tag_lo == tacavg_pkg::TAG_W'(c))
                        ? tacavg_pkg::SUM_W'(val_lo) : '0)
                     + ((tag_hi == tacavg_pkg::TAG_W'(c))
                        ? tacavg_pkg::SUM_W'(val_hi) : '0);
         counts_add[c] = counts_ff[c]
                       + tacavg_pkg::CNT_W'(tag_lo == tacavg_pkg::TAG_W'(c))
                       + tacavg_pkg::CNT_W'(tag_hi == tacavg_pkg::TAG_W'(c));
      end
   end

   // Take words up to the bound, else flag a drop; at burst end push, start over
   always_comb begin
      sums_in    = sums_ff;
      counts_in  = counts_ff;
      words_in   = words_ff;
      dropped_in = dropped_ff;
      job_push   = 1'b0;
      job.sums    = room ? sums_add : sums_ff;
      job.counts  = room ? counts_add : counts_ff;
      job.dropped = dropped_ff | ~room;
      if (accept) begin
         if (room) begin
            sums_in   = sums_add;
            counts_in = counts_add;
            words_in  = words_ff + 1'b1;
         end else begin
            dropped_in = 1'b1;
         end
         if (item.burst_end) begin
            job_push   = 1'b1;
            sums_in    = '0;
            counts_in  = '0;
            words_in   = '0;
            dropped_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sums_ff    <= '0;
         counts_ff  <= '0;
         words_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         sums_ff    <= sums_in;
         counts_ff  <= counts_in;
         words_ff   <= words_in;
         dropped_ff <= dropped_in;
      end
   end

endmodule

// ===== rtl/core/tacavg_jobq.sv =====
module tacavg_jobq (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  tacavg_pkg::job_type            push_job,
   input  logic                           pop,
   output tacavg_pkg::job_type            head_job,
   output tacavg_pkg::jobq_status_type    status
);

   tacavg_pkg::job_type            jobq_ff [tacavg_pkg::JOBQ_DEPTH];
   logic [tacavg_pkg::JOBQ_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [tacavg_pkg::JOBQ_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [tacavg_pkg::JOBQ_AW:0]   cnt_ff, cnt_in;

   assign status.empty = (cnt_ff == '0);
   assign status.full  = (cnt_ff == (tacavg_pkg::JOBQ_AW + 1)'(tacavg_pkg::JOBQ_DEPTH));
   assign head_job     = jobq_ff[rd_ptr_ff];

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == tacavg_pkg::JOBQ_AW'(tacavg_pkg::JOBQ_DEPTH - 1))
                   ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == tacavg_pkg::JOBQ_AW'(tacavg_pkg::JOBQ_DEPTH - 1))
                   ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store the pushed burst
   always_ff @(posedge clock) begin
      if (push) begin
         jobq_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/core/tacavg_back.sv =====
module tacavg_back (
   input  logic                           clock,
   input  logic                           reset,
   input  tacavg_pkg::job_type            head_job,
   input  tacavg_pkg::jobq_status_type    jobq_status,
   output logic                           job_pop,
   input  logic                           rsp_pop,
   output logic                           rsp_valid,
   output tacavg_pkg::rsp_item_type       rsp_item
);

   tacavg_pkg::back_state_type state_ff, state_in;

   logic [tacavg_pkg::CH_IDX_W-1:0]  ch_ff, ch_in;
   logic [tacavg_pkg::CNT_W-1:0]     rem_ff, rem_in;
   logic [tacavg_pkg::SUM_W-1:0]     quo_ff, quo_in;
   logic [tacavg_pkg::DIV_CNT_W-1:0] step_ff, step_in;
   logic [tacavg_pkg::AVG_W-1:0]     avg_ff, avg_in;
   logic                             upd_ff, upd_in;
   logic [tacavg_pkg::AVG_W-1:0]     held_ff [tacavg_pkg::CHANNELS];
   logic                             held_we;
   logic                             rsp_valid_ff, rsp_valid_in;
   tacavg_pkg::rsp_item_type         rsp_ff, rsp_in;

   logic [tacavg_pkg::SUM_W-1:0] cur_sum;
   logic [tacavg_pkg::CNT_W-1:0] cur_cnt;
   logic [tacavg_pkg::CNT_W:0]   shifted, diff;
   logic                         ge;
   logic                         last_ch;
   logic                         last_step;
   logic                         out_free;

   assign cur_sum   = head_job.sums[ch_ff];
   assign cur_cnt   = head_job.counts[ch_ff];
   assign last_ch   = (ch_ff == tacavg_pkg::CH_IDX_W'(tacavg_pkg::CHANNELS - 1));
   assign last_step = (step_ff == tacavg_pkg::DIV_CNT_W'(1));
   assign out_free  = !rsp_valid_ff || rsp_pop;

   // Restoring divide step: one quotient bit per cycle
   assign shifted = {rem_ff, quo_ff[tacavg_pkg::SUM_W-1]};
   assign diff    = shifted - {1'b0, cur_cnt};
   assign ge      = (shifted >= {1'b0, cur_cnt});

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tacavg_pkg::BK_IDLE: begin
            if (!jobq_status.empty) state_in = tacavg_pkg::BK_LOAD;
         end
         tacavg_pkg::BK_LOAD: begin
            state_in = (cur_cnt != '0) ? tacavg_pkg::BK_DIV : tacavg_pkg::BK_EMIT;
         end
         tacavg_pkg::BK_DIV: begin
            if (last_step) state_in = tacavg_pkg::BK_EMIT;
         end
         tacavg_pkg::BK_EMIT: begin
            if (out_free) state_in = last_ch ? tacavg_pkg::BK_IDLE : tacavg_pkg::BK_LOAD;
         end
         default: state_in = tacavg_pkg::BK_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      ch_in        = ch_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      avg_in       = avg_ff;
      upd_in       = upd_ff;
      held_we      = 1'b0;
      job_pop      = 1'b0;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      unique case (state_ff)
         tacavg_pkg::BK_IDLE: begin
            ch_in = '0;
         end
         tacavg_pkg::BK_LOAD: begin
            rem_in  = '0;
            quo_in  = cur_sum;
            step_in = tacavg_pkg::DIV_CNT_W'(tacavg_pkg::DIV_STEPS);
            upd_in  = (cur_cnt != '0);
            avg_in  = held_ff[ch_ff];
         end
         tacavg_pkg::BK_DIV: begin
            rem_in  = ge ? diff[tacavg_pkg::CNT_W-1:0] : shifted[tacavg_pkg::CNT_W-1:0];
            quo_in  = {quo_ff[tacavg_pkg::SUM_W-2:0], ge};
            step_in = step_ff - 1'b1;
            if (last_step) begin
               avg_in  = quo_in[tacavg_pkg::AVG_W-1:0];
               held_we = 1'b1;
            end
         end
         tacavg_pkg::BK_EMIT: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_in.channel   = tacavg_pkg::TAG_W'(ch_ff);
               rsp_in.average   = avg_ff;
               rsp_in.updated   = upd_ff;
               rsp_in.overflow  = head_job.dropped;
               rsp_in.run_last  = last_ch;
               ch_in            = ch_ff + 1'b1;
               job_pop          = last_ch;
            end
         end
         default: begin
            ch_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tacavg_pkg::BK_IDLE;
         ch_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold divider and result payload
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
      avg_ff  <= avg_in;
      upd_ff  <= upd_in;
      rsp_ff  <= rsp_in;
   end

   // Held averages survive across bursts; reset clears them
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < tacavg_pkg::CHANNELS; c++) begin
            held_ff[c] <= '0;
         end
      end else if (held_we) begin
         held_ff[ch_ff] <= avg_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // The divider only runs on a channel that saw samples
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tacavg_pkg::BK_DIV) |-> (cur_cnt != '0))
      else $error("divider running with zero count");

   // Partial remainder stays below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tacavg_pkg::BK_DIV) |-> (rem_ff < cur_cnt))
      else $error("remainder not below divisor");

   // A burst is only retired from a nonempty queue, on the last channel
   a_pop_last: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> (!jobq_status.empty && last_ch && out_free))
      else $error("burst retired early");

endmodule

// ===== rtl/core/tagged_adc_channel_averager_core.sv =====
// Channel   Ports                        Direction  Item
// ------------------------------------------------------------------------
// request   push, full, req_data         in         fifo_word, burst_end
// response  empty, pop, rsp_data         out        channel, average, updated,
//                                                   overflow, run_last
//
// The front takes one word per cycle while the burst queue has room; full
// rises only while two finished bursts are queued, the one in the back end included.
// The back end loads each channel in turn; a channel that saw samples then runs
// the 19-step restoring divide before its result is handed to the output
// register, which waits while the receiver stalls; the back end returns to idle
// to pick up each burst.
// Reset is synchronous and clears the sums, counts and held averages at once.
// A stalled result side stops the back end only; the front keeps filling until the burst queue is full.
module tagged_adc_channel_averager_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   output logic                     full,
   input  tacavg_pkg::req_item_type req_data,
   output logic                     empty,
   input  logic                     pop,
   output tacavg_pkg::rsp_item_type rsp_data
);

   logic                           accept;
   logic                           job_push;
   logic                           job_pop;
   logic                           rsp_valid;
   tacavg_pkg::job_type            push_job;
   tacavg_pkg::job_type            head_job;
   tacavg_pkg::jobq_status_type    jobq_status;

   assign full   = jobq_status.full;
   assign accept = push && !jobq_status.full;
   assign empty  = !rsp_valid;

   tacavg_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .item     (req_data),
      .job_push (job_push),
      .job      (push_job)
   );

   tacavg_jobq u_jobq (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .pop      (job_pop),
      .head_job (head_job),
      .status   (jobq_status)
   );

   tacavg_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_job    (head_job),
      .jobq_status (jobq_status),
      .job_pop     (job_pop),
      .rsp_pop     (pop),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_data)
   );

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;

   logic                     clock;
   logic                     reset;
   logic                     push;
   logic                     full;
   tacavg_pkg::req_item_type req_data;
   logic                     empty;
   logic                     pop;
   tacavg_pkg::rsp_item_type rsp_data;

   tagged_adc_channel_averager_core DUT (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   // Predicted burst state, kept alongside the block
   logic [tacavg_pkg::SUM_W-1:0]  acc_sum    [tacavg_pkg::CHANNELS];
   logic [tacavg_pkg::CNT_W-1:0]  acc_count  [tacavg_pkg::CHANNELS];
   logic [tacavg_pkg::AVG_W-1:0]  held_avg   [tacavg_pkg::CHANNELS];
   logic [tacavg_pkg::WCNT_W-1:0] words_taken;
   logic                          words_dropped;

   // Channel results still owed by the block, oldest first
   tacavg_pkg::rsp_item_type expected_avgs [$];

   int  mismatch_count = 0;
   int  items_sent     = 0;
   int  burst_left     = 0;
   bit  gaps_on        = 1'b1;
   int  pop_mode       = 0;
   int  pop_phase      = 0;

   // Free-running clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard limit on run length
   initial begin
      #4000000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Reset the predicted state
   task automatic clear_averages();
      for (int ch = 0; ch < tacavg_pkg::CHANNELS; ch++) begin
         acc_sum[ch]   = '0;
         acc_count[ch] = '0;
         held_avg[ch]  = '0;
      end
      words_taken   = '0;
      words_dropped = 1'b0;
   endtask

   // Accumulate one accepted word; on burst end, queue one result per channel
   task automatic predict_burst_word(input tacavg_pkg::req_item_type item);
      logic [tacavg_pkg::HALF_W-1:0] half;
      logic [tacavg_pkg::TAG_W-1:0]  tag;
      tacavg_pkg::rsp_item_type      res;
      if (words_taken < tacavg_pkg::WCNT_W'(tacavg_pkg::MAX_BURST_WORDS)) begin
         for (int h = 0; h < 2; h++) begin
            half = item.fifo_word[h*tacavg_pkg::HALF_W +: tacavg_pkg::HALF_W];
            tag  = half[tacavg_pkg::TAG_LSB +: tacavg_pkg::TAG_W];
            // Skip tags past the channel count
            if (int'(tag) < tacavg_pkg::CHANNELS) begin
               acc_sum[tag]   = acc_sum[tag]
                              + tacavg_pkg::SUM_W'(half[tacavg_pkg::VAL_W-1:0]);
               acc_count[tag] = acc_count[tag] + 1'b1;
            end
         end
         words_taken = words_taken + 1'b1;
      end else begin
         words_dropped = 1'b1;
      end
      if (item.burst_end) begin
         for (int ch = 0; ch < tacavg_pkg::CHANNELS; ch++) begin
            res.updated = (acc_count[ch] != '0);
            if (res.updated)
               held_avg[ch] = tacavg_pkg::AVG_W'(acc_sum[ch] / acc_count[ch]);
            res.channel  = tacavg_pkg::TAG_W'(ch);
            res.average  = held_avg[ch];
            res.overflow = words_dropped;
            res.run_last = (ch == tacavg_pkg::CHANNELS - 1);
            expected_avgs.push_back(res);
            acc_sum[ch]   = '0;
            acc_count[ch] = '0;
         end
         words_taken   = '0;
         words_dropped = 1'b0;
      end
   endtask

   function automatic logic [tacavg_pkg::HALF_W-1:0] make_half(
      input logic top, input int tag, input logic [tacavg_pkg::VAL_W-1:0] val);
      return {top, tacavg_pkg::TAG_W'(tag), val};
   endfunction

   // Offer one item, holding it until the block takes it
   task automatic send_word(input logic [tacavg_pkg::WORD_W-1:0] w, input logic last);
      tacavg_pkg::req_item_type item;
      int gap;
      item.fifo_word = w;
      item.burst_end = last;
      @(negedge clock);
      if (gaps_on && burst_left == 0) begin
         gap = $urandom_range(1, 6);
         push <= 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      push     <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (full);
      predict_burst_word(item);
      items_sent++;
      if (burst_left > 0) burst_left--;
   endtask

   // Stop sending and wait until every owed result has come back
   task automatic wait_drained();
      @(negedge clock);
      push <= 1'b0;
      while (expected_avgs.size() != 0) @(posedge clock);
   endtask

   // Extremes, every channel, truncation, ignored top bit, held averages
   task automatic test_directed();
      // All zero on channel 0; others stay at reset value
      send_word(32'h0000_0000, 1'b1);
      // Full-scale on channel 7 high half, channel 0 low half, top bit set on the high half
      send_word({make_half(1'b1, 7, 12'hFFF), make_half(1'b0, 0, 12'hFFF)}, 1'b1);
      // Channels 0 to 6 once or twice, with truncating means
      send_word({make_half(1'b0, 1, 12'd2), make_half(1'b1, 1, 12'd1)}, 1'b0);
      send_word({make_half(1'b0, 3, 12'd10), make_half(1'b0, 2, 12'd7)}, 1'b0);
      send_word({make_half(1'b1, 5, 12'hAAA), make_half(1'b0, 4, 12'h555)}, 1'b0);
      send_word({make_half(1'b0, 3, 12'd3), make_half(1'b1, 6, 12'h800)}, 1'b0);
      send_word({make_half(1'b0, 2, 12'd8), make_half(1'b0, 0, 12'h001)}, 1'b1);
      // Only channel 4 this time; the rest keep their held values
      send_word({make_half(1'b1, 4, 12'h7FF), make_half(1'b1, 4, 12'h800)}, 1'b1);
      // Channels 5 and 2 once, then all ones: channel 7 twice at full scale, top bits set
      send_word(32'h5A5A_A5A5, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b1);
      // Burst end word with two small samples for channel 6 only
      send_word({make_half(1'b0, 6, 12'd0), make_half(1'b0, 6, 12'd1)}, 1'b1);
   endtask

   // Burst bound: exactly full, then past the bound with a dropped end word
   task automatic test_bound();
      wait_drained();
      gaps_on = 1'b0;
      // Largest possible sum on one channel
      for (int i = 0; i < tacavg_pkg::MAX_BURST_WORDS; i++)
         send_word({make_half(1'($urandom_range(0, 1)), 5, 12'hFFF),
                    make_half(1'($urandom_range(0, 1)), 5, 12'hFFF)},
                   i == tacavg_pkg::MAX_BURST_WORDS - 1);
      gaps_on = 1'b1;
      for (int i = 0; i < tacavg_pkg::MAX_BURST_WORDS + 2; i++)
         send_word($urandom, i == tacavg_pkg::MAX_BURST_WORDS + 1);
   endtask

   // Random bursts, mostly short with shaped content, some pure noise
   task automatic test_random();
      int len;
      int tag_hi;
      bit noise;
      logic [tacavg_pkg::VAL_W-1:0]  v [2];
      logic [tacavg_pkg::WORD_W-1:0] w;
      while (items_sent < 210) begin
         len    = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 8);
         tag_hi = $urandom_range(0, tacavg_pkg::CHANNELS - 1);
         noise  = ($urandom_range(0, 5) == 0);
         gaps_on = ($urandom_range(0, 3) != 0);
         for (int i = 0; i < len; i++) begin
            if (noise) begin
               w = $urandom;
            end else begin
               for (int h = 0; h < 2; h++)
                  case ($urandom_range(0, 7))
                     0: v[h] = '0;
                     1: v[h] = '1;
                     default: v[h] = tacavg_pkg::VAL_W'($urandom);
                  endcase
               w = {make_half(1'($urandom_range(0, 1)), $urandom_range(0, tag_hi), v[1]),
                    make_half(1'($urandom_range(0, 1)), $urandom_range(0, tag_hi), v[0])};
            end
            send_word(w, i == len - 1);
         end
      end
      gaps_on = 1'b1;
   endtask

   // Receiver stall pattern: switch between always ready, coin toss and mostly stalled
   always @(negedge clock) begin
      if (pop_phase == 0) begin
         pop_mode  = $urandom_range(0, 2);
         pop_phase = $urandom_range(20, 80);
      end else begin
         pop_phase--;
      end
      case (pop_mode)
         0:       pop <= 1'b1;
         1:       pop <= 1'($urandom_range(0, 1));
         default: pop <= ($urandom_range(0, 4) == 0);
      endcase
   end

   // Compare each accepted result with the oldest owed one
   always @(posedge clock) begin
      tacavg_pkg::rsp_item_type want;
      if (!reset && pop && !empty) begin
         if (expected_avgs.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: ch=%0d avg=%0d upd=%0b ovf=%0b last=%0b",
                        rsp_data.channel, rsp_data.average, rsp_data.updated,
                        rsp_data.overflow, rsp_data.run_last);
         end else begin
            want = expected_avgs.pop_front();
            if (rsp_data.channel !== want.channel || rsp_data.average !== want.average ||
                rsp_data.updated !== want.updated || rsp_data.overflow !== want.overflow ||
                rsp_data.run_last !== want.run_last) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $write("mismatch: exp ch=%0d avg=%0d upd=%0b ovf=%0b last=%0b, ",
                         want.channel, want.average, want.updated, want.overflow,
                         want.run_last);
                  $display("got ch=%0d avg=%0d upd=%0b ovf=%0b last=%0b",
                           rsp_data.channel, rsp_data.average,
                           rsp_data.updated, rsp_data.overflow, rsp_data.run_last);
               end
            end
         end
      end
   end

   initial begin
      reset    = 1'b1;
      push     = 1'b0;
      req_data = '0;
      clear_averages();
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_bound();
      test_random();

      // Drain, then allow the back end to settle
      wait_drained();
      repeat (200) @(posedge clock);
      if (mismatch_count == 0 && expected_avgs.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
